FILE: rtl/http_payload_classifier_assert.svh
// Assertion macros shared by the classifier checker.
`ifndef HTTP_PAYLOAD_CLASSIFIER_ASSERT_SVH
`define HTTP_PAYLOAD_CLASSIFIER_ASSERT_SVH

// Clocked assertion, masked while reset is asserted.
`define HPC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that stays live through reset.
`define HPC_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/hpc_pkg.sv
// Shared types and constants of the HTTP payload classifier.
`default_nettype none

package hpc_pkg;

  localparam int COUNT_W   = 32;
  localparam int HIST_W    = 48;
  localparam int WIN_W     = 56;
  localparam int NUM_METH  = 6;

  localparam logic [1:0] MSG_NOT_HTTP = 2'd0;
  localparam logic [1:0] MSG_RESPONSE = 2'd1;
  localparam logic [1:0] MSG_REQUEST  = 2'd2;

  localparam logic [2:0] METHOD_NONE    = 3'd0;
  localparam logic [2:0] METHOD_POST    = 3'd1;
  localparam logic [2:0] METHOD_HEAD    = 3'd2;
  localparam logic [2:0] METHOD_GET     = 3'd3;
  localparam logic [2:0] METHOD_PUT     = 3'd4;
  localparam logic [2:0] METHOD_TRACE   = 3'd5;
  localparam logic [2:0] METHOD_CONNECT = 3'd6;

  // ASCII patterns, last character in the low byte
  localparam logic [31:0] PAT_HTTP    = 32'h48545450;
  localparam logic [31:0] PAT_POST    = 32'h504F5354;
  localparam logic [31:0] PAT_HEAD    = 32'h48454144;
  localparam logic [23:0] PAT_GET     = 24'h474554;
  localparam logic [23:0] PAT_PUT     = 24'h505554;
  localparam logic [39:0] PAT_TRACE   = 40'h5452414345;
  localparam logic [55:0] PAT_CONNECT = 56'h434F4E4E454354;

  // Byte position at which a match of "HTTP" started at byte 0
  localparam logic [2:0] POS_HTTP_START = 3'd3;
  localparam logic [2:0] POS_SAT        = 3'd4;

  typedef struct packed {
    logic [1:0] msg_class;
    logic [2:0] method;
  } verdict_t;

  typedef struct packed {
    logic [1:0]         message_class;
    logic [2:0]         method_code;
    logic [COUNT_W-1:0] request_total;
    logic [COUNT_W-1:0] response_total;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/hpc_channels.sv
// Valid/ready channel interfaces for payload bytes and classification results.
`default_nettype none

interface hpc_in_if import hpc_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       last_byte;

  modport source (output valid, output payload_byte, output last_byte, input ready);
  modport sink   (input valid, input payload_byte, input last_byte, output ready);
endinterface

interface hpc_out_if import hpc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         message_class;
  logic [2:0]         method_code;
  logic [COUNT_W-1:0] request_total;
  logic [COUNT_W-1:0] response_total;

  modport source (output valid, output message_class, output method_code,
                  output request_total, output response_total, input ready);
  modport sink   (input valid, input message_class, input method_code,
                  input request_total, input response_total, output ready);
endinterface

`default_nettype wire

FILE: rtl/hpc_scan.sv
// Per-payload pattern scanner: byte history, found flags and the verdict at the last byte.
`default_nettype none

module hpc_scan import hpc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire logic [7:0] payload_byte,
  input  wire logic       last_byte,
  output verdict_t        verdict
);

  logic [HIST_W-1:0]   hist_r, hist_nxt;
  logic [2:0]          pos_r, pos_nxt;
  logic                http_r, http_nxt;
  logic                start_r, start_nxt;
  logic [NUM_METH-1:0] meth_r, meth_nxt;

  logic [WIN_W-1:0]    win;
  logic                hit_http;
  logic [NUM_METH-1:0] hits;
  logic                http_now;
  logic                start_now;
  logic [NUM_METH-1:0] meth_now;

  assign win      = {hist_r, payload_byte};
  assign hit_http = (win[31:0] == PAT_HTTP);

  always_comb begin
    hits[0] = (win[31:0] == PAT_POST);
    hits[1] = (win[31:0] == PAT_HEAD);
    hits[2] = (win[23:0] == PAT_GET);
    hits[3] = (win[23:0] == PAT_PUT);
    hits[4] = (win[39:0] == PAT_TRACE);
    hits[5] = (win      == PAT_CONNECT);
  end

  assign http_now  = http_r | hit_http;
  assign start_now = start_r | (hit_http && (pos_r == POS_HTTP_START));
  assign meth_now  = meth_r | hits;

  // Verdict is only meaningful on the last byte of a payload
  always_comb begin
    verdict.msg_class = MSG_NOT_HTTP;
    verdict.method    = METHOD_NONE;
    if (http_now) begin
      if (start_now) begin
        verdict.msg_class = MSG_RESPONSE;
      end else begin
        verdict.msg_class = MSG_REQUEST;
        if (meth_now[0])      verdict.method = METHOD_POST;
        else if (meth_now[1]) verdict.method = METHOD_HEAD;
        else if (meth_now[2]) verdict.method = METHOD_GET;
        else if (meth_now[3]) verdict.method = METHOD_PUT;
        else if (meth_now[4]) verdict.method = METHOD_TRACE;
        else if (meth_now[5]) verdict.method = METHOD_CONNECT;
      end
    end
  end

  always_comb begin
    hist_nxt  = hist_r;
    pos_nxt   = pos_r;
    http_nxt  = http_r;
    start_nxt = start_r;
    meth_nxt  = meth_r;
    if (accept) begin
      if (last_byte) begin
        hist_nxt  = '0;
        pos_nxt   = '0;
        http_nxt  = 1'b0;
        start_nxt = 1'b0;
        meth_nxt  = '0;
      end else begin
        hist_nxt  = win[HIST_W-1:0];
        pos_nxt   = (pos_r < POS_SAT) ? pos_r + 3'd1 : pos_r;
        http_nxt  = http_now;
        start_nxt = start_now;
        meth_nxt  = meth_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r  <= '0;
      pos_r   <= '0;
      http_r  <= 1'b0;
      start_r <= 1'b0;
      meth_r  <= '0;
    end else begin
      hist_r  <= hist_nxt;
      pos_r   <= pos_nxt;
      http_r  <= http_nxt;
      start_r <= start_nxt;
      meth_r  <= meth_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/http_payload_classifier.sv
// Top level of the HTTP payload classifier.
// Usage:
//   in_chan takes one payload byte per transaction, with last_byte set on
//   the final byte of a TCP payload. Non-final bytes give no result.
//   out_chan gives one result per payload: message class (not HTTP,
//   response, request), method for requests, and saturating 32-bit totals
//   of requests and responses that include this payload.
// Result: registered in the output register, or in the skid entry while
//   out_chan is stalled. Throughput: one byte per cycle while in_chan.ready
//   is high; pattern matching is a single pass of compares over a seven-byte
//   window between the history register and the result register.
// Stall: results sit in an output register backed by one skid entry.
//   Bytes keep flowing while one result waits; in_chan.ready drops only
//   when both the output register and the skid entry hold results.
// Reset: synchronous, active low; clears byte history, found flags,
//   totals and both result slots.
`default_nettype none

module http_payload_classifier import hpc_pkg::*; (
  input wire logic  clk,
  input wire logic  rst_n,
  hpc_in_if.sink    in_chan,
  hpc_out_if.source out_chan
);

  logic               in_fire;
  logic               produce;
  verdict_t           verdict;
  result_t            new_res;
  logic [COUNT_W-1:0] req_cnt_r, req_cnt_nxt;
  logic [COUNT_W-1:0] rsp_cnt_r, rsp_cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               skid_valid_r, skid_valid_nxt;
  result_t            out_res_r, out_res_nxt;
  result_t            skid_res_r, skid_res_nxt;

  assign in_chan.ready = !skid_valid_r;
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign produce       = in_fire && in_chan.last_byte;

  hpc_scan u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_fire),
    .payload_byte (in_chan.payload_byte),
    .last_byte    (in_chan.last_byte),
    .verdict      (verdict)
  );

  always_comb begin
    req_cnt_nxt = req_cnt_r;
    rsp_cnt_nxt = rsp_cnt_r;
    if (produce) begin
      if (verdict.msg_class == MSG_REQUEST && req_cnt_r != '1) begin
        req_cnt_nxt = req_cnt_r + 1'b1;
      end
      if (verdict.msg_class == MSG_RESPONSE && rsp_cnt_r != '1) begin
        rsp_cnt_nxt = rsp_cnt_r + 1'b1;
      end
    end
  end

  always_comb begin
    new_res.message_class  = verdict.msg_class;
    new_res.method_code    = verdict.method;
    new_res.request_total  = req_cnt_nxt;
    new_res.response_total = rsp_cnt_nxt;
  end

  // Output register with one skid entry behind it
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_res_nxt    = out_res_r;
    skid_res_nxt   = skid_res_r;
    if (!out_valid_r || out_chan.ready) begin
      if (skid_valid_r) begin
        out_res_nxt    = skid_res_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else if (produce) begin
        out_res_nxt   = new_res;
        out_valid_nxt = 1'b1;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (produce) begin
      skid_res_nxt   = new_res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_cnt_r    <= '0;
      rsp_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      req_cnt_r    <= req_cnt_nxt;
      rsp_cnt_r    <= rsp_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.message_class  = out_res_r.message_class;
  assign out_chan.method_code    = out_res_r.method_code;
  assign out_chan.request_total  = out_res_r.request_total;
  assign out_chan.response_total = out_res_r.response_total;

endmodule

`default_nettype wire

FILE: rtl/hpc_checker.sv
// Port-level assertions for the HTTP payload classifier, bound to the top level.
`default_nettype none
`include "http_payload_classifier_assert.svh"

module hpc_checker import hpc_pkg::*; (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [1:0]         message_class,
  input wire logic [2:0]         method_code,
  input wire logic [COUNT_W-1:0] request_total,
  input wire logic [COUNT_W-1:0] response_total
);

  // A stalled result must hold still
  `HPC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(message_class) && $stable(method_code) && $stable(request_total) && $stable(response_total), "result changed while stalled")

  // Only requests carry a method
  `HPC_ASSERT(a_method_req_only, out_valid && message_class != MSG_REQUEST |-> method_code == METHOD_NONE, "method on non-request")

  // A delivered request or response is already counted
  `HPC_ASSERT(a_req_counted, out_valid && message_class == MSG_REQUEST |-> request_total != '0, "request not counted")
  `HPC_ASSERT(a_rsp_counted, out_valid && message_class == MSG_RESPONSE |-> response_total != '0, "response not counted")

  // Nothing comes out right after reset, and in_chan is not stalled
  `HPC_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid && (in_ready || !in_valid), "result after reset")

endmodule

bind http_payload_classifier hpc_checker u_hpc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .message_class  (out_chan.message_class),
  .method_code    (out_chan.method_code),
  .request_total  (out_chan.request_total),
  .response_total (out_chan.response_total)
);

`default_nettype wire
